// ===== design/tpcc_pkg.sv =====
`timescale 1ns / 1ps

package tpcc_pkg;

  // one side's time as decimal digits mm:ss
  typedef struct packed {
    logic [3:0] min_tens;
    logic [3:0] min_ones;
    logic [2:0] sec_tens;
    logic [3:0] sec_ones;
  } time_t;

  // configuration register indexes
  localparam logic REG_START_SECONDS    = 1'b0;
  localparam logic REG_TICKS_PER_SECOND = 1'b1;

  localparam logic [12:0] START_RESET = 13'd300;
  localparam logic [7:0]  TPS_RESET   = 8'd76;
  localparam logic [12:0] MAX_SECONDS = 13'd5999;

  // 5:00 for the reset value of 300 seconds
  localparam time_t RESET_TIME = '{min_tens: 4'd0, min_ones: 4'd5,
                                   sec_tens: 3'd0, sec_ones: 4'd0};

  // reciprocal constants: x / 60 = (x * 8739) >> 19 for x <= 5999,
  // x / 10 = (x * 205) >> 11 for x <= 99
  localparam logic [13:0] RECIP_60 = 14'd8739;
  localparam logic [7:0]  RECIP_10 = 8'd205;

endpackage

// ===== design/two_player_countdown_clock_top.sv =====
`timescale 1ns / 1ps

// two-player countdown clock
// in_ channel: one transfer per poll tick, carrying the switch and reset
//   button levels; rising edges act (switch first, then reset)
// out_ channel: one transfer per input transfer with both sides' times as
//   mm:ss digits, the active side and the running flag, as they stand after
//   button handling and before that tick's count
// cfg_ channel: register writes (0 start_seconds, 1 ticks_per_second);
//   cfg_ready is always high
// path: an input transfer is held in the input register, then the update stage
//   loads its result into the result register
// throughput: one tick per cycle while the result register drains and no start
//   time is converting, set by the state update in digit form; a start_seconds
//   write holds in_tready low until the digit split unit has converted it
// reset: both times load 5:00, first side active, clock stopped, prescaler
//   and button history cleared
// stall: with out_tready low the result register holds, an empty input register
//   still takes one more tick, then in_tready drops
module two_player_countdown_clock_top (
  input  logic        clk,
  input  logic        rst_n,
  // input: [0] switch_button, [1] reset_button, [7:2] zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // output: [3:0] first_min_tens, [7:4] first_min_ones, [10:8] first_sec_tens,
  // [14:11] first_sec_ones, [18:15] second_min_tens, [22:19] second_min_ones,
  // [25:23] second_sec_tens, [29:26] second_sec_ones, [30] first_side_active,
  // [31] clock_running
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);

  // configuration register; start_seconds lives in digit form in the split unit
  logic [7:0]  tps_r;

  // clock state
  tpcc_pkg::time_t first_r, first_nxt;
  tpcc_pkg::time_t second_r, second_nxt;
  logic        fa_r, fa_nxt;
  logic        run_r, run_nxt;
  logic        prev_sw_r;
  logic        prev_rs_r;
  logic [7:0]  tc_r, tc_nxt;

  // input register
  logic        in_v_r;
  logic        sw_r;
  logic        rs_r;

  // result register
  logic        out_valid_r;
  logic [31:0] out_data_r, out_data_nxt;

  logic        cfg_xfer;
  logic        load_start;
  logic        split_busy;
  tpcc_pkg::time_t load_time;
  logic        adv;
  logic        step;

  // combinational step values
  logic        sw_edge;
  logic        rs_edge;
  tpcc_pkg::time_t t1_a;
  tpcc_pkg::time_t t2_a;
  logic        fa_a;
  logic        run_a;
  logic [7:0]  tps_eff;
  logic [7:0]  tc_inc;
  logic        sec_hit;

  // one second off in digit form, holding at zero
  function automatic tpcc_pkg::time_t dec_time(input tpcc_pkg::time_t t);
    tpcc_pkg::time_t r;
    r = t;
    if (t.sec_ones != 4'd0) begin
      r.sec_ones = t.sec_ones - 4'd1;
    end else if (t.sec_tens != 3'd0) begin
      r.sec_ones = 4'd9;
      r.sec_tens = t.sec_tens - 3'd1;
    end else if (t.min_ones != 4'd0) begin
      r.sec_ones = 4'd9;
      r.sec_tens = 3'd5;
      r.min_ones = t.min_ones - 4'd1;
    end else if (t.min_tens != 4'd0) begin
      r.sec_ones = 4'd9;
      r.sec_tens = 3'd5;
      r.min_ones = 4'd9;
      r.min_tens = t.min_tens - 4'd1;
    end
    return r;
  endfunction

  function automatic logic is_zero(input tpcc_pkg::time_t t);
    return (t == '0);
  endfunction

  assign cfg_ready  = 1'b1;
  assign cfg_xfer   = cfg_valid && cfg_ready;
  assign load_start = cfg_xfer && (cfg_index == tpcc_pkg::REG_START_SECONDS);

  tpcc_digit_split u_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_i    (load_start),
    .seconds_i (cfg_data),
    .busy_o    (split_busy),
    .digits_o  (load_time)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= tpcc_pkg::TPS_RESET;
    end else if (cfg_xfer && (cfg_index == tpcc_pkg::REG_TICKS_PER_SECOND)) begin
      tps_r <= cfg_data[7:0];
    end
  end

  // update stage moves when the result register is free or being drained
  assign adv       = !out_valid_r || out_tready;
  assign step      = in_v_r && adv;
  assign in_tready = (!in_v_r || adv) && !split_busy && !load_start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end else if (step) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      sw_r <= in_tdata[0];
      rs_r <= in_tdata[1];
    end
  end

  // button handling, then the prescaler and countdown
  always_comb begin
    sw_edge = sw_r && !prev_sw_r;
    rs_edge = rs_r && !prev_rs_r;
    fa_a    = sw_edge ? !fa_r : fa_r;
    run_a   = sw_edge ? 1'b1 : run_r;
    t1_a    = first_r;
    t2_a    = second_r;
    if (rs_edge) begin
      t1_a  = load_time;
      t2_a  = load_time;
      run_a = 1'b0;
    end

    out_data_nxt = {run_a, fa_a,
                    t2_a.sec_ones, t2_a.sec_tens, t2_a.min_ones, t2_a.min_tens,
                    t1_a.sec_ones, t1_a.sec_tens, t1_a.min_ones, t1_a.min_tens};

    // a limit of zero acts as one
    tps_eff    = (tps_r == 8'd0) ? 8'd1 : tps_r;
    tc_inc     = tc_r + 8'd1;
    sec_hit    = run_a && (tc_inc >= tps_eff);
    tc_nxt     = tc_r;
    first_nxt  = t1_a;
    second_nxt = t2_a;
    if (run_a) begin
      tc_nxt = sec_hit ? 8'd0 : tc_inc;
    end
    if (sec_hit) begin
      if (fa_a) begin
        first_nxt = dec_time(t1_a);
      end else begin
        second_nxt = dec_time(t2_a);
      end
    end
    fa_nxt  = fa_a;
    run_nxt = run_a && !is_zero(first_nxt) && !is_zero(second_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r   <= tpcc_pkg::RESET_TIME;
      second_r  <= tpcc_pkg::RESET_TIME;
      fa_r      <= 1'b1;
      run_r     <= 1'b0;
      prev_sw_r <= 1'b0;
      prev_rs_r <= 1'b0;
      tc_r      <= 8'd0;
    end else if (step) begin
      first_r   <= first_nxt;
      second_r  <= second_nxt;
      fa_r      <= fa_nxt;
      run_r     <= run_nxt;
      prev_sw_r <= sw_r;
      prev_rs_r <= rs_r;
      tc_r      <= tc_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // no tick taken while a new start time is being converted
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    split_busy |-> !in_tready)
    else $error("input taken during start time conversion");

  // a full input register with a stalled result must not take another tick
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input register overrun");

  // the clock never stays running with a side at zero
  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> (!is_zero(first_r) && !is_zero(second_r)))
    else $error("running with a time at zero");

  // digit ranges hold on both sides for all digits but the minute tens
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (first_r.sec_tens <= 3'd5) && (first_r.sec_ones <= 4'd9) &&
    (second_r.sec_tens <= 3'd5) && (second_r.sec_ones <= 4'd9) &&
    (first_r.min_ones <= 4'd9) && (second_r.min_ones <= 4'd9))
    else $error("time digit out of range");

endmodule

// ===== design/tpcc_digit_split.sv =====
`timescale 1ns / 1ps

// converts a seconds value into mm:ss digits in a chain of registered steps
module tpcc_digit_split (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load_i,
  input  logic [12:0]        seconds_i,
  output logic               busy_o,
  output tpcc_pkg::time_t    digits_o
);

  logic [3:0]  vld_r;
  logic [12:0] t0_r;
  logic [12:0] t1_r;
  logic [6:0]  m1_r;
  logic [6:0]  m2_r;
  logic [5:0]  s2_r;
  logic [3:0]  mt2_r;
  logic [3:0]  mt3_r;
  logic [3:0]  mo3_r;
  logic [2:0]  st3_r;
  logic [5:0]  s3_r;
  tpcc_pkg::time_t digits_r;

  logic [12:0] clamp_sec;
  logic [26:0] prod_m;
  logic [12:0] m_x60;
  logic [14:0] prod_mt;
  logic [6:0]  mt_x10;
  logic [13:0] prod_st;
  logic [5:0]  st_x10;

  assign clamp_sec = (seconds_i > tpcc_pkg::MAX_SECONDS) ? tpcc_pkg::MAX_SECONDS : seconds_i;
  assign prod_m    = 27'(t0_r) * 27'(tpcc_pkg::RECIP_60);
  assign m_x60     = 13'(m1_r) * 13'd60;
  assign prod_mt   = 15'(m1_r) * 15'(tpcc_pkg::RECIP_10);
  assign mt_x10    = 7'(mt2_r) * 7'd10;
  assign prod_st   = 14'(s2_r) * 14'(tpcc_pkg::RECIP_10);
  assign st_x10    = 6'(st3_r) * 6'd10;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      digits_r <= tpcc_pkg::RESET_TIME;
    end else begin
      vld_r <= {vld_r[2:0], load_i};
      if (vld_r[3]) begin
        digits_r <= '{min_tens: mt3_r, min_ones: mo3_r, sec_tens: st3_r,
                      sec_ones: 4'(s3_r - st_x10)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      t0_r <= clamp_sec;
    end
    if (vld_r[0]) begin
      t1_r <= t0_r;
      m1_r <= prod_m[25:19];
    end
    if (vld_r[1]) begin
      s2_r  <= 6'(t1_r - m_x60);
      m2_r  <= m1_r;
      mt2_r <= prod_mt[14:11];
    end
    if (vld_r[2]) begin
      mt3_r <= mt2_r;
      mo3_r <= 4'(m2_r - mt_x10);
      st3_r <= prod_st[13:11];
      s3_r  <= s2_r;
    end
  end

  assign busy_o   = |vld_r;
  assign digits_o = digits_r;

endmodule

// ===== dv/two_player_countdown_clock_top_tb.sv =====
`timescale 1ns / 1ps

// self-checking bench for the two-player countdown clock: button ticks go in on
// in_, every tick yields one display transfer on out_ which is checked field by
// field against a cycle-free model of the clock kept here
module two_player_countdown_clock_top_tb;

  // idle cycles without any transfer before the run is declared hung; the worst
  // legal case is a source gap plus a sink stall plus the start_seconds convert
  localparam int WATCHDOG_LIMIT = 2000;
  // cycles allowed after the last result before a register write or the end
  localparam int SETTLE_CYCLES  = 6;
  localparam int MAX_PRINTED    = 40;
  localparam int RANDOM_PHASES  = 15;

  // what the display shows for one tick
  typedef struct {
    tpcc_pkg::time_t first_side;
    tpcc_pkg::time_t second_side;
    logic  first_active;
    logic  running;
  } display_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [31:0] out_tdata;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic        cfg_index  = tpcc_pkg::REG_START_SECONDS;
  logic [12:0] cfg_data   = '0;

  // clock model: register copies and game state
  logic [12:0] start_reg;
  logic [7:0]  tps_reg;
  logic [12:0] first_secs;
  logic [12:0] second_secs;
  logic        first_act;
  logic        running;
  logic        prev_sw;
  logic        prev_rs;
  logic [7:0]  prescale;

  // displays predicted for accepted ticks, oldest first
  display_t pending_displays[$];

  // stimulus controls
  bit source_gaps = 1'b0;
  bit sink_stalls = 1'b0;
  int sink_hold   = 0;
  int sw_hold     = 0;
  int rs_hold     = 0;

  // bookkeeping
  int err_count   = 0;
  int quiet_cycles = 0;
  int n_ticks     = 0;
  int n_results   = 0;
  int n_cfg       = 0;
  int n_switches  = 0;
  int n_reloads   = 0;
  int n_seconds   = 0;
  int n_expiries  = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  two_player_countdown_clock_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // clock model
  // ---------------------------------------------------------------------------

  function automatic tpcc_pkg::time_t to_digits(input logic [12:0] secs);
    int    mins;
    int    rem;
    tpcc_pkg::time_t d;
    mins = secs / 60;
    rem  = secs % 60;
    d.min_tens = 4'(mins / 10);
    d.min_ones = 4'(mins % 10);
    d.sec_tens = 3'(rem / 10);
    d.sec_ones = 4'(rem % 10);
    return d;
  endfunction

  // start value with the clamp to 99:59
  function automatic logic [12:0] reload_secs();
    return (start_reg > tpcc_pkg::MAX_SECONDS) ? tpcc_pkg::MAX_SECONDS : start_reg;
  endfunction

  task automatic reset_clock_model();
    start_reg   = tpcc_pkg::START_RESET;
    tps_reg     = tpcc_pkg::TPS_RESET;
    first_secs  = tpcc_pkg::START_RESET;
    second_secs = tpcc_pkg::START_RESET;
    first_act   = 1'b1;
    running     = 1'b0;
    prev_sw     = 1'b0;
    prev_rs     = 1'b0;
    prescale    = '0;
  endtask

  // one poll tick: button edges, display snapshot, then the count
  task automatic advance_clock(input logic sw, input logic rs, output display_t shown);
    // switch edge is handled before reset edge
    if (sw && !prev_sw) begin
      first_act = !first_act;
      running   = 1'b1;
      n_switches++;
    end
    // reload keeps the prescaler and the active side
    if (rs && !prev_rs) begin
      first_secs  = reload_secs();
      second_secs = reload_secs();
      running     = 1'b0;
      n_reloads++;
    end
    prev_sw = sw;
    prev_rs = rs;

    shown.first_side   = to_digits(first_secs);
    shown.second_side  = to_digits(second_secs);
    shown.first_active = first_act;
    shown.running      = running;

    // "reached or above" compare: a zero limit acts like one, and a prescaler
    // left above a lowered limit clears on the next running tick
    if (running) begin
      prescale = prescale + 8'd1;
      if (prescale >= tps_reg) begin
        prescale = '0;
        if (first_act && first_secs != 0) begin
          first_secs = first_secs - 13'd1;
          n_seconds++;
        end else if (!first_act && second_secs != 0) begin
          second_secs = second_secs - 13'd1;
          n_seconds++;
        end
      end
    end
    // a flag at zero stops the clock at the end of the tick
    if (first_secs == 0 || second_secs == 0) begin
      if (running) n_expiries++;
      running = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTED) $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  // out_tdata fields from the lowest bit up
  function automatic display_t unpack_display(input logic [31:0] w);
    display_t d;
    d.first_side.min_tens  = w[3:0];
    d.first_side.min_ones  = w[7:4];
    d.first_side.sec_tens  = w[10:8];
    d.first_side.sec_ones  = w[14:11];
    d.second_side.min_tens = w[18:15];
    d.second_side.min_ones = w[22:19];
    d.second_side.sec_tens = w[25:23];
    d.second_side.sec_ones = w[29:26];
    d.first_active         = w[30];
    d.running              = w[31];
    return d;
  endfunction

  task automatic compare_side(input string side, input tpcc_pkg::time_t got,
                              input tpcc_pkg::time_t want);
    if (got.min_tens !== want.min_tens)
      report_mismatch($sformatf("%s_min_tens got %0d exp %0d", side, got.min_tens,
                                want.min_tens));
    if (got.min_ones !== want.min_ones)
      report_mismatch($sformatf("%s_min_ones got %0d exp %0d", side, got.min_ones,
                                want.min_ones));
    if (got.sec_tens !== want.sec_tens)
      report_mismatch($sformatf("%s_sec_tens got %0d exp %0d", side, got.sec_tens,
                                want.sec_tens));
    if (got.sec_ones !== want.sec_ones)
      report_mismatch($sformatf("%s_sec_ones got %0d exp %0d", side, got.sec_ones,
                                want.sec_ones));
  endtask

  // every out_ transfer is matched against the oldest prediction
  always @(posedge clk) begin
    display_t got;
    display_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      got = unpack_display(out_tdata);
      if (pending_displays.size() == 0) begin
        report_mismatch($sformatf("display %h with no tick outstanding", out_tdata));
      end else begin
        want = pending_displays.pop_front();
        compare_side("first", got.first_side, want.first_side);
        compare_side("second", got.second_side, want.second_side);
        if (got.first_active !== want.first_active)
          report_mismatch($sformatf("first_side_active got %0b exp %0b", got.first_active,
                                    want.first_active));
        if (got.running !== want.running)
          report_mismatch($sformatf("clock_running got %0b exp %0b", got.running,
                                    want.running));
      end
    end
  end

  // hang detector: cycles in a row with no transfer on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d displays outstanding",
                 quiet_cycles, pending_displays.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // sink side: random stall bursts while enabled
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold  <= sink_hold - 1;
      out_tready <= (sink_hold == 1);
    end else if (sink_stalls && $urandom_range(0, 11) == 0) begin
      sink_hold  <= $urandom_range(1, 18);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one tick transfer; tvalid stays high after the transfer so back-to-back
  // ticks never drop it, whoever goes idle next lowers it
  task automatic send_tick(input logic sw, input logic rs);
    display_t shown;
    if (source_gaps && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, rs, sw};
    do @(posedge clk); while (!in_tready);
    advance_clock(sw, rs, shown);
    pending_displays.push_back(shown);
    n_ticks++;
  endtask

  // source holds off until every display has come back
  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    while (pending_displays.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register writes only happen with the block drained
  task automatic write_reg(input logic idx, input logic [12:0] value);
    wait_results_done();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == tpcc_pkg::REG_START_SECONDS) start_reg = value;
    else tps_reg = value[7:0];
    n_cfg++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // game-like button activity: mostly short presses, some reloads, some noise
  task automatic play_ticks(input int count);
    int   r;
    logic sw;
    logic rs;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        sw = $urandom_range(0, 1);
        rs = $urandom_range(0, 1);
      end else begin
        if (sw_hold == 0 && r < 22) sw_hold = $urandom_range(1, 3);
        if (rs_hold == 0 && r >= 96) rs_hold = $urandom_range(1, 2);
        sw = (sw_hold != 0);
        rs = (rs_hold != 0);
        if (sw_hold != 0) sw_hold--;
        if (rs_hold != 0) rs_hold--;
      end
      send_tick(sw, rs);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset state: 5:00 on both sides, first side active, stopped
  task automatic test_power_on();
    send_tick(1'b0, 1'b0);
  endtask

  task automatic test_button_edges();
    send_tick(1'b1, 1'b0);  // switch edge: side toggles, clock starts
    send_tick(1'b1, 1'b0);  // held, no new edge
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);  // a new edge toggles back
    send_tick(1'b0, 1'b1);  // reload stops, side and prescaler kept
    send_tick(1'b0, 1'b1);  // held reset
    send_tick(1'b1, 1'b1);  // switch edge while reset still held
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);  // both edges at once: toggle, then stop
    send_tick(1'b0, 1'b0);
  endtask

  task automatic test_register_extremes();
    // zero ticks per second counts every running tick, start clamps to 99:59
    write_reg(tpcc_pkg::REG_TICKS_PER_SECOND, 13'd0);
    write_reg(tpcc_pkg::REG_START_SECONDS, 13'h1fff);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    // zero start: switch edge shows running for one tick only
    write_reg(tpcc_pkg::REG_START_SECONDS, 13'd0);
    send_tick(1'b0, 1'b0);  // old times still shown until a reload
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    // prescaler left above a lowered limit
    write_reg(tpcc_pkg::REG_TICKS_PER_SECOND, 13'd255);
    write_reg(tpcc_pkg::REG_START_SECONDS, 13'd5400);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    repeat (4) send_tick(1'b0, 1'b0);
    write_reg(tpcc_pkg::REG_TICKS_PER_SECOND, 13'd2);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
  endtask

  // the source stops mid-stream until everything has drained, then resumes
  task automatic test_drain_pause();
    source_gaps = 1'b1;
    sink_stalls = 1'b1;
    play_ticks(12);
    wait_results_done();
    play_ticks(12);
  endtask

  task automatic test_random_play();
    logic [12:0] start_val;
    logic [7:0]  tps_val;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      // each side's idling is on for most phases, off for some
      source_gaps = ($urandom_range(0, 3) != 0);
      sink_stalls = ($urandom_range(0, 3) != 0);

      // short times and fast prescale so flags fall often; now and then the
      // full field range, upper data bits on the 8-bit register included
      start_val = ($urandom_range(0, 4) == 0) ? 13'($urandom_range(0, 8191))
                                              : 13'($urandom_range(0, 90));
      tps_val   = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 4));
      if ($urandom_range(0, 1)) begin
        write_reg(tpcc_pkg::REG_START_SECONDS, start_val);
        write_reg(tpcc_pkg::REG_TICKS_PER_SECOND, {5'($urandom_range(0, 31)), tps_val});
      end else begin
        write_reg(tpcc_pkg::REG_TICKS_PER_SECOND, {5'($urandom_range(0, 31)), tps_val});
        write_reg(tpcc_pkg::REG_START_SECONDS, start_val);
      end

      // usually a new game: reload then start
      if ($urandom_range(0, 9) < 7) begin
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        sw_hold = 0;
        rs_hold = 0;
      end
      play_ticks($urandom_range(25, 45));
      if ($urandom_range(0, 4) == 0) wait_results_done();
      play_ticks($urandom_range(5, 15));
    end
  endtask

  // last stretch at full rate on both sides
  task automatic test_full_rate();
    source_gaps = 1'b0;
    sink_stalls = 1'b0;
    write_reg(tpcc_pkg::REG_START_SECONDS, 13'd601);  // 10:01, borrows across minutes
    write_reg(tpcc_pkg::REG_TICKS_PER_SECOND, 13'd1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    play_ticks(60);
  endtask

  initial begin
    reset_clock_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_power_on();
    test_button_edges();
    test_register_extremes();
    test_drain_pause();
    test_random_play();
    test_full_rate();

    wait_results_done();
    $display("covered %0d ticks, %0d displays checked, %0d register writes",
             n_ticks, n_results, n_cfg);
    $display("side switches %0d, reloads %0d, seconds counted %0d, flags fallen %0d",
             n_switches, n_reloads, n_seconds, n_expiries);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== two_player_countdown_clock_top.f =====
design/tpcc_pkg.sv
design/tpcc_digit_split.sv
design/two_player_countdown_clock_top.sv
dv/two_player_countdown_clock_top_tb.sv
